/* hw/rtl/rpnc_pkg.sv */
// ============================================================================
// RPN calculator package
// Shared action and status codes, controller states, and the command and
// status bundles between the controller and the datapath.
// ============================================================================
package rpnc_pkg;

    localparam int DATA_W          = 32;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int IN_USER_W       = 3;
    localparam int OUT_USER_W      = 6;

    typedef enum logic [2:0] {
        ACT_ADD     = 3'd0,
        ACT_SUB     = 3'd1,
        ACT_MUL     = 3'd2,
        ACT_DIV     = 3'd3,
        ACT_PRINT   = 3'd4,
        ACT_QUIT    = 3'd5,
        ACT_PUSH    = 3'd6,
        ACT_INVALID = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_INVALID   = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_DIVZERO   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_TOP,
        S_RD_B,
        S_RD_A,
        S_EXEC,
        S_DIV,
        S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    latch_in;
        logic    rd_second;
        logic    cap_b;
        logic    cap_a;
        logic    res_init;
        status_t res_status;
        logic    res_empty;
        logic    res_quit;
        logic    set_status;
        logic    cap_shown;
        logic    alu_load;
        logic    div_start;
        logic    cap_quot;
        logic    wr_push;
        logic    wr_result;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    count_zero;
        logic    count_lt2;
        logic    count_full;
        logic    b_zero;
        logic    div_done;
        logic    out_busy;
    } stat_t;

endpackage

/* hw/rtl/rpnc_div.sv */
// ============================================================================
// RPN calculator divider
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero. Result wraps at the data width.
// ============================================================================
module rpnc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rpnc_pkg::DATA_W-1:0]  num,
    input  logic [rpnc_pkg::DATA_W-1:0]  den,
    output logic                         done,
    output logic [rpnc_pkg::DATA_W-1:0]  quotient
);

    localparam int W  = rpnc_pkg::DATA_W;
    localparam int NW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic [W:0]    trial;

    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = num[W-1] ^ den[W-1];
            rem_next  = '0;
            quo_next  = num[W-1] ? (W'(0) - num) : num;
            den_next  = den[W-1] ? (W'(0) - den) : den;
        end
        else if (busy_reg)
        begin
            // keep the remainder only when the trial subtract does not borrow
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + NW'(1);
            if (cnt_reg == NW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - quo_reg) : quo_reg;

endmodule

/* hw/rtl/rpnc_dpath.sv */
// ============================================================================
// RPN calculator datapath
// Stack memory, entry count, operand registers, ALU, divider and the
// result register toward the output stream.
// ============================================================================
module rpnc_dpath #(
    parameter int STACK_DEPTH = rpnc_pkg::STACK_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [rpnc_pkg::DATA_W-1:0]      s_tdata,
    input  logic [rpnc_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rpnc_pkg::DATA_W-1:0]      m_tdata,
    output logic [rpnc_pkg::OUT_USER_W-1:0]  m_tuser,
    input  rpnc_pkg::cmd_t                   cmd,
    output rpnc_pkg::stat_t                  stat
);

    localparam int W  = rpnc_pkg::DATA_W;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [W-1:0]           mem [STACK_DEPTH];
    logic [W-1:0]           mem_q_reg;

    rpnc_pkg::action_t      act_reg, act_next;
    logic [W-1:0]           opd_reg, opd_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [W-1:0]           a_reg, a_next;
    logic [W-1:0]           b_reg, b_next;
    logic [W-1:0]           r_reg, r_next;
    rpnc_pkg::status_t      res_status_reg, res_status_next;
    logic                   res_shown_reg, res_shown_next;
    logic [W-1:0]           res_value_reg, res_value_next;
    logic                   res_empty_reg, res_empty_next;
    logic                   res_quit_reg, res_quit_next;
    logic                   m_valid_reg, m_valid_next;
    logic [W-1:0]           m_data_reg, m_data_next;
    logic [rpnc_pkg::OUT_USER_W-1:0] m_user_reg, m_user_next;

    logic [CW-1:0]          count_m1, count_m2;
    logic [AW-1:0]          rd_addr, wr_addr;
    logic                   wr_en;
    logic [W-1:0]           wr_data;
    logic [W-1:0]           alu_out;
    logic                   div_done;
    logic [W-1:0]           div_quot;

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);
    assign rd_addr  = cmd.rd_second ? count_m2[AW-1:0] : count_m1[AW-1:0];
    assign wr_addr  = cmd.wr_push ? count_reg[AW-1:0] : count_m2[AW-1:0];
    assign wr_en    = cmd.wr_push | cmd.wr_result;
    assign wr_data  = cmd.wr_push ? opd_reg : r_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    rpnc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (a_reg),
        .den      (b_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        case (act_reg)
            rpnc_pkg::ACT_SUB: alu_out = a_reg - b_reg;
            rpnc_pkg::ACT_MUL: alu_out = a_reg * b_reg;
            default:           alu_out = a_reg + b_reg;
        endcase
    end

    always_comb
    begin
        act_next        = act_reg;
        opd_next        = opd_reg;
        count_next      = count_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        r_next          = r_reg;
        res_status_next = res_status_reg;
        res_shown_next  = res_shown_reg;
        res_value_next  = res_value_reg;
        res_empty_next  = res_empty_reg;
        res_quit_next   = res_quit_reg;

        if (cmd.latch_in)
        begin
            act_next = rpnc_pkg::action_t'(s_tuser);
            opd_next = s_tdata;
        end
        if (cmd.cap_b)
        begin
            b_next = mem_q_reg;
        end
        if (cmd.cap_a)
        begin
            a_next = mem_q_reg;
        end
        if (cmd.alu_load)
        begin
            r_next = alu_out;
        end
        if (cmd.cap_quot)
        begin
            r_next = div_quot;
        end
        if (cmd.wr_push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.wr_result)
        begin
            count_next = count_m1;
        end
        if (cmd.res_init)
        begin
            res_status_next = cmd.res_status;
            res_shown_next  = 1'b0;
            res_value_next  = '0;
            res_empty_next  = cmd.res_empty;
            res_quit_next   = cmd.res_quit;
        end
        if (cmd.set_status)
        begin
            res_status_next = cmd.res_status;
        end
        if (cmd.cap_shown)
        begin
            res_shown_next = 1'b1;
            res_value_next = mem_q_reg;
        end
    end

    // output register: hold while the sink stalls
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            m_valid_next = 1'b1;
            m_data_next  = res_value_reg;
            m_user_next  = {res_quit_reg, res_empty_reg, res_shown_reg, res_status_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        opd_reg        <= opd_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        r_reg          <= r_next;
        res_status_reg <= res_status_next;
        res_shown_reg  <= res_shown_next;
        res_value_reg  <= res_value_next;
        res_empty_reg  <= res_empty_next;
        res_quit_reg   <= res_quit_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign stat.action     = act_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.count_lt2  = (count_reg < CW'(2));
    assign stat.count_full = (count_reg == CW'(STACK_DEPTH));
    assign stat.b_zero     = (b_reg == '0);
    assign stat.div_done   = div_done;
    assign stat.out_busy   = m_valid_reg & ~m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* hw/rtl/rpnc_ctrl.sv */
// ============================================================================
// RPN calculator controller
// Sequences one request at a time: decode, stack reads, execute, divide,
// write back and hand the result to the output register.
// ============================================================================
module rpnc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  rpnc_pkg::stat_t  stat,
    output rpnc_pkg::cmd_t   cmd
);

    rpnc_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpnc_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = rpnc_pkg::S_DECODE;
                end
            end
            rpnc_pkg::S_DECODE:
            begin
                case (stat.action) inside
                    rpnc_pkg::ACT_ADD, rpnc_pkg::ACT_SUB,
                    rpnc_pkg::ACT_MUL, rpnc_pkg::ACT_DIV:
                        state_next = stat.count_lt2 ? rpnc_pkg::S_DONE : rpnc_pkg::S_RD_B;
                    rpnc_pkg::ACT_PRINT:
                        state_next = stat.count_zero ? rpnc_pkg::S_DONE : rpnc_pkg::S_RD_TOP;
                    default:
                        state_next = rpnc_pkg::S_DONE;
                endcase
            end
            rpnc_pkg::S_RD_TOP: state_next = rpnc_pkg::S_DONE;
            rpnc_pkg::S_RD_B:   state_next = rpnc_pkg::S_RD_A;
            rpnc_pkg::S_RD_A:   state_next = rpnc_pkg::S_EXEC;
            rpnc_pkg::S_EXEC:
            begin
                if (stat.action != rpnc_pkg::ACT_DIV)
                begin
                    state_next = rpnc_pkg::S_WRITE;
                end
                else if (stat.b_zero)
                begin
                    state_next = rpnc_pkg::S_DONE;
                end
                else
                begin
                    state_next = rpnc_pkg::S_DIV;
                end
            end
            rpnc_pkg::S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = rpnc_pkg::S_WRITE;
                end
            end
            rpnc_pkg::S_WRITE:  state_next = rpnc_pkg::S_DONE;
            rpnc_pkg::S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = rpnc_pkg::S_IDLE;
                end
            end
            default:            state_next = rpnc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.res_status = rpnc_pkg::ST_OK;
        s_tready       = 1'b0;
        unique case (state_reg)
            rpnc_pkg::S_IDLE:
            begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
            end
            rpnc_pkg::S_DECODE:
            begin
                cmd.res_init = 1'b1;
                case (stat.action) inside
                    rpnc_pkg::ACT_ADD, rpnc_pkg::ACT_SUB,
                    rpnc_pkg::ACT_MUL, rpnc_pkg::ACT_DIV:
                    begin
                        if (stat.count_lt2)
                        begin
                            cmd.res_status = rpnc_pkg::ST_UNDERFLOW;
                        end
                    end
                    rpnc_pkg::ACT_PRINT:
                        cmd.res_empty = stat.count_zero;
                    rpnc_pkg::ACT_QUIT:
                        cmd.res_quit = 1'b1;
                    rpnc_pkg::ACT_PUSH:
                    begin
                        if (stat.count_full)
                        begin
                            cmd.res_status = rpnc_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            cmd.wr_push = 1'b1;
                        end
                    end
                    default:
                        cmd.res_status = rpnc_pkg::ST_INVALID;
                endcase
            end
            rpnc_pkg::S_RD_TOP: cmd.cap_shown = 1'b1;
            rpnc_pkg::S_RD_B:
            begin
                cmd.cap_b     = 1'b1;
                cmd.rd_second = 1'b1;
            end
            rpnc_pkg::S_RD_A:   cmd.cap_a = 1'b1;
            rpnc_pkg::S_EXEC:
            begin
                if (stat.action != rpnc_pkg::ACT_DIV)
                begin
                    cmd.alu_load = 1'b1;
                end
                else if (stat.b_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.res_status = rpnc_pkg::ST_DIVZERO;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
            end
            rpnc_pkg::S_DIV:    cmd.cap_quot = stat.div_done;
            rpnc_pkg::S_WRITE:  cmd.wr_result = 1'b1;
            rpnc_pkg::S_DONE:   cmd.load_out = ~stat.out_busy;
            default:            cmd.latch_in = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpnc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/rpn_stack_calculator.sv */
// ============================================================================
// RPN stack calculator
// Reverse-Polish integer stack machine with a 32-bit signed data path.
// ============================================================================
// Each request carries an action in s_tuser and a value in s_tdata and gives
// exactly one result on the m_ side. Requests are handled one at a time. From
// acceptance to the result register: push, quit, invalid, underflow and
// overflow pass DECODE and DONE; print adds RD_TOP; add/sub/mul pass DECODE,
// RD_B, RD_A, EXEC, WRITE and DONE; div by zero skips WRITE; div waits in DIV
// between EXEC and WRITE on the divider, which retires one quotient bit per
// cycle. The next request is taken in the cycle in which the current result
// first sits in the output register; a stalled output holds it back and delays
// the next request. The stack is a single-port-write, registered-read memory of
// STACK_DEPTH words, so an arithmetic request reads its two operands in turn.
// ============================================================================
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rpnc_pkg::STACK_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rpnc_pkg::DATA_W-1:0]      s_tdata,   // [31:0] operand
    input  logic [rpnc_pkg::IN_USER_W-1:0]   s_tuser,   // [2:0] action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rpnc_pkg::DATA_W-1:0]      m_tdata,   // [31:0] shown_value
    output logic [rpnc_pkg::OUT_USER_W-1:0]  m_tuser    // [2:0] status, [3] shown_valid,
                                                        // [4] stack_empty, [5] quit_seen
);

    rpnc_pkg::cmd_t  cmd;
    rpnc_pkg::stat_t stat;

    rpnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rpnc_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
